// ===== hw/rtl/ole_pkg.sv =====
// ----------------------------------------------------------------------------
// ole_pkg: shared types and constants of the ordered list engine
// Holds the capacity, derived widths, command and status codes, the cell
// control codes and the packed transaction types of both channels.
// ----------------------------------------------------------------------------
package ole_pkg;

	// Number of list cells, and widths that follow from it.
	localparam int CAPACITY = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Command codes.
	localparam logic [2:0] CMD_ADD_FRONT  = 3'd0;
	localparam logic [2:0] CMD_ADD_BACK   = 3'd1;
	localparam logic [2:0] CMD_DROP_FRONT = 3'd2;
	localparam logic [2:0] CMD_DROP_BACK  = 3'd3;
	localparam logic [2:0] CMD_INSERT     = 3'd4;
	localparam logic [2:0] CMD_ERASE      = 3'd5;
	localparam logic [2:0] CMD_FIND       = 3'd6;
	localparam logic [2:0] CMD_CLEAR      = 3'd7;

	// Status codes.
	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_IGNORED = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	// Cell operations.
	localparam logic [1:0] CELL_HOLD       = 2'd0;
	localparam logic [1:0] CELL_LOAD       = 2'd1;
	localparam logic [1:0] CELL_FROM_LEFT  = 2'd2;
	localparam logic [1:0] CELL_FROM_RIGHT = 2'd3;

	typedef struct packed {
		logic [1:0] op;
		logic       cmp_en;
	} cell_ctl_t;

	typedef struct packed {
		logic [2:0]         command;
		logic signed [15:0] position;
		logic signed [31:0] item_value;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic       found;
		logic [3:0] found_index;
		logic [4:0] entry_count;
	} rsp_t;

endpackage

// ===== hw/rtl/ole_cell.sv =====
// ----------------------------------------------------------------------------
// ole_cell: one storage cell of the list chain
// Holds one entry, takes a new value from the command, from its left or
// right neighbour, and registers a match of its entry against the key.
// ----------------------------------------------------------------------------
module ole_cell
	import ole_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cell_ctl_t          ctl,
	input  logic signed [31:0] left_value,
	input  logic signed [31:0] right_value,
	input  logic signed [31:0] load_value,
	output logic signed [31:0] value,
	output logic               match
);

	logic signed [31:0] value_q;
	logic               match_q;

	// Entry register: payload, no reset needed.
	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_LOAD:       value_q <= load_value;
			CELL_FROM_LEFT:  value_q <= left_value;
			CELL_FROM_RIGHT: value_q <= right_value;
			default:         value_q <= value_q;
		endcase
	end

	// Compare the entry as it stands before this transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else begin
			match_q <= ctl.cmp_en && (value_q == load_value);
		end
	end

	assign value = value_q;
	assign match = match_q;

endmodule

// ===== hw/rtl/ole_prio.sv =====
// ----------------------------------------------------------------------------
// ole_prio: first-match priority encoder
// Reports whether any cell matched and the lowest index that did.
// ----------------------------------------------------------------------------
module ole_prio
	import ole_pkg::*;
(
	input  logic [CAPACITY-1:0] match,
	output logic                hit,
	output logic [IDX_W-1:0]    index
);

	// Scan from the back so that the lowest matching index wins.
	always_comb begin
		index = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (match[i]) begin
				index = IDX_W'(i);
			end
		end
	end

	assign hit = |match;

endmodule

// ===== hw/rtl/ordered_list_engine.sv =====
// ----------------------------------------------------------------------------
// ordered_list_engine: bounded ordered list of signed 32-bit values
// A chain of cells holds the list in index order; a command shifts, loads
// or compares the cells that it affects in the cycle in which it is accepted.
//
//   Channel   Signals          Direction  Handshake
//   request   start, req       in         accepted when start and not busy
//   result    done, rsp        out        one-cycle strobe, cannot be held off
//
// One transaction is accepted every cycle; busy stays low.
// The result appears in the cycle after acceptance, set by the registered
// match bits of the cells feeding the first-match encoder.
// Reset empties the list at once; no clearing pass is needed, as cells at
// or above the count are never read.
// ----------------------------------------------------------------------------
module ordered_list_engine
	import ole_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_next;
	logic               done_q;
	logic [1:0]         status_q;
	logic [1:0]         status_next;
	logic               accept;
	logic               full;
	logic               empty;
	logic               pos_le_zero;
	logic               pos_ge_count;
	logic               pos_neg;
	logic               do_put;
	logic               do_take;
	logic               do_find;
	logic [IDX_W-1:0]   target;
	logic [14:0]        count_wide;
	cell_ctl_t          ctl [CAPACITY];
	logic signed [31:0] cell_value [CAPACITY];
	logic [CAPACITY-1:0] match;
	logic               hit;
	logic [IDX_W-1:0]   hit_index;
	logic [IDX_W+3:0]   hit_index_wide;
	logic [CNT_W+4:0]   count_out_wide;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Position checks against the current count.
	assign full         = (count_q == CNT_W'(CAPACITY));
	assign empty        = (count_q == '0);
	assign pos_neg      = req.position[15];
	assign pos_le_zero  = pos_neg || (req.position == '0);
	assign count_wide   = {{(15 - CNT_W){1'b0}}, count_q};
	assign pos_ge_count = !pos_neg && (req.position[14:0] >= count_wide);

	// Decode the command into a put, a take or a find at a target index.
	always_comb begin
		do_put      = 1'b0;
		do_take     = 1'b0;
		do_find     = 1'b0;
		target      = '0;
		status_next = ST_DONE;
		count_next  = count_q;
		case (req.command)
			CMD_ADD_FRONT, CMD_ADD_BACK, CMD_INSERT: begin
				if (full) begin
					status_next = ST_FULL;
				end else begin
					do_put     = 1'b1;
					count_next = count_q + 1'b1;
					if (req.command == CMD_ADD_FRONT
						|| (req.command == CMD_INSERT && pos_le_zero)) begin
						target = '0;
					end else if (req.command == CMD_ADD_BACK || pos_ge_count) begin
						target = count_q[IDX_W-1:0];
					end else begin
						target = req.position[IDX_W-1:0];
					end
				end
			end
			CMD_DROP_FRONT, CMD_DROP_BACK: begin
				if (empty) begin
					status_next = ST_IGNORED;
				end else begin
					do_take    = 1'b1;
					count_next = count_q - 1'b1;
					if (req.command == CMD_DROP_FRONT) begin
						target = '0;
					end else begin
						target = IDX_W'(count_q - 1'b1);
					end
				end
			end
			CMD_ERASE: begin
				if (pos_neg || pos_ge_count) begin
					status_next = ST_IGNORED;
				end else begin
					do_take    = 1'b1;
					count_next = count_q - 1'b1;
					target     = req.position[IDX_W-1:0];
				end
			end
			CMD_FIND: begin
				do_find = 1'b1;
			end
			CMD_CLEAR: begin
				count_next = '0;
			end
			default: begin
				status_next = ST_DONE;
			end
		endcase
	end

	// Per-cell control: load at and shift up above a put, shift down from a take.
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			ctl[i].op     = CELL_HOLD;
			ctl[i].cmp_en = accept && do_find && (CNT_W'(i) < count_q);
			if (accept && do_put) begin
				if (IDX_W'(i) == target) begin
					ctl[i].op = CELL_LOAD;
				end else if (IDX_W'(i) > target) begin
					ctl[i].op = CELL_FROM_LEFT;
				end
			end else if (accept && do_take) begin
				if (IDX_W'(i) >= target) begin
					ctl[i].op = CELL_FROM_RIGHT;
				end
			end
		end
	end

	// The chain of cells.
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic signed [31:0] left_v;
		logic signed [31:0] right_v;
		if (g == 0) begin : g_first
			assign left_v = req.item_value;
		end else begin : g_inner_l
			assign left_v = cell_value[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign right_v = cell_value[g];
		end else begin : g_inner_r
			assign right_v = cell_value[g+1];
		end
		ole_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl[g]),
			.left_value  (left_v),
			.right_value (right_v),
			.load_value  (req.item_value),
			.value       (cell_value[g]),
			.match       (match[g])
		);
	end

	// First matching cell of the previous find.
	ole_prio u_prio (
		.match (match),
		.hit   (hit),
		.index (hit_index)
	);

	// Count, status and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			done_q   <= 1'b0;
			status_q <= ST_DONE;
		end else begin
			done_q <= accept;
			if (accept) begin
				count_q  <= count_next;
				status_q <= status_next;
			end
		end
	end

	// Result fields carry the low bits of the index and the count.
	assign hit_index_wide = {4'b0, hit_index};
	assign count_out_wide = {5'b0, count_q};

	assign done             = done_q;
	assign rsp.status       = status_q;
	assign rsp.found        = hit;
	assign rsp.found_index  = hit_index_wide[3:0];
	assign rsp.entry_count  = count_out_wide[4:0];

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the ordered list engine
// Commands are driven on the falling clock edge and results are checked on
// the rising edge against a queue-based model of the bounded list. Directed
// tests cover the empty list, the position extremes and a full list. Random
// phases then mix growing and shrinking command sequences with noise, under
// varying sender gaps.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ole_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int DRAIN_CYCLES  = 8;
	localparam int PHASE_ITEMS   = 317;
	localparam int SWING_ITEMS   = 48;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	req_t req    = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	// Model of the list contents, front at index 0.
	logic signed [31:0] list_entries[$];
	// Results still to come, oldest first.
	rsp_t pending_rsp[$];

	int sender_idle_pct = 0;
	int n_errors        = 0;
	int n_sent          = 0;
	int n_checked       = 0;
	int n_full          = 0;
	int n_ignored       = 0;
	int n_found         = 0;

	ordered_list_engine dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	// Clock, period 12 ns.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Apply one command to the list model and return the result it gives.
	function automatic rsp_t apply_to_list(input req_t r);
		rsp_t o;
		int   pos;
		int   n;
		o   = '0;
		pos = int'(r.position);
		n   = list_entries.size();
		o.status = ST_DONE;
		case (r.command)
			CMD_ADD_FRONT, CMD_ADD_BACK, CMD_INSERT: begin
				if (n >= CAPACITY) begin
					o.status = ST_FULL;
				end else if (r.command == CMD_ADD_FRONT ||
						(r.command == CMD_INSERT && pos <= 0)) begin
					list_entries.insert(0, r.item_value);
				end else if (r.command == CMD_ADD_BACK || pos >= n) begin
					list_entries.insert(n, r.item_value);
				end else begin
					list_entries.insert(pos, r.item_value);
				end
			end
			CMD_DROP_FRONT: begin
				if (n == 0) o.status = ST_IGNORED;
				else list_entries.delete(0);
			end
			CMD_DROP_BACK: begin
				if (n == 0) o.status = ST_IGNORED;
				else list_entries.delete(n - 1);
			end
			CMD_ERASE: begin
				if (pos < 0 || pos >= n) o.status = ST_IGNORED;
				else list_entries.delete(pos);
			end
			CMD_FIND: begin
				for (int k = 0; k < n; k++) begin
					if (list_entries[k] == r.item_value) begin
						o.found       = 1'b1;
						o.found_index = 4'(k);
						break;
					end
				end
			end
			default: begin
				list_entries.delete();
			end
		endcase
		o.entry_count = 5'(list_entries.size());
		return o;
	endfunction

	// Drive one command, wait for it to be taken and record its result.
	task automatic send_command(input logic [2:0] cmd, input int pos,
			input logic signed [31:0] value);
		req_t r;
		r.command    = cmd;
		r.position   = 16'(pos);
		r.item_value = value;
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_rsp.insert(pending_rsp.size(), apply_to_list(r));
		n_sent++;
	endtask

	task automatic report_field(input string field, input int unsigned exp_val,
			input int unsigned act_val);
		$display("%0t ns: %s mismatch, expected %0d, actual %0d",
			$time, field, exp_val, act_val);
		n_errors++;
	endtask

	// Result checker: every strobe must match the oldest expectation.
	always @(posedge clk) begin
		rsp_t exp_rsp;
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, actual %h",
					$time, rsp);
				n_errors++;
			end else begin
				exp_rsp = pending_rsp[0];
				pending_rsp.delete(0);
				n_checked++;
				if (exp_rsp.status == ST_FULL) n_full++;
				if (exp_rsp.status == ST_IGNORED) n_ignored++;
				if (exp_rsp.found) n_found++;
				if (rsp.status !== exp_rsp.status)
					report_field("status", 32'(exp_rsp.status), 32'(rsp.status));
				if (rsp.found !== exp_rsp.found)
					report_field("found", 32'(exp_rsp.found), 32'(rsp.found));
				if (rsp.found_index !== exp_rsp.found_index)
					report_field("found_index", 32'(exp_rsp.found_index),
						32'(rsp.found_index));
				if (rsp.entry_count !== exp_rsp.entry_count)
					report_field("entry_count", 32'(exp_rsp.entry_count),
						32'(rsp.entry_count));
			end
		end
	end

	// Watchdog.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Timeout after %0d cycles", CYCLE_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	// Pops, erase and find on an empty list.
	task automatic test_empty_list();
		send_command(CMD_DROP_FRONT, 0, 32'sd0);
		send_command(CMD_DROP_BACK, 0, 32'sd0);
		send_command(CMD_ERASE, 0, 32'sd0);
		send_command(CMD_FIND, 0, 32'sd0);
	endtask

	// Insert clamping, filling to capacity, overflow and erase range checks.
	task automatic test_fill_and_overflow();
		send_command(CMD_ADD_FRONT, 0, 32'sh8000_0000);
		send_command(CMD_ADD_BACK, 0, 32'sh7fff_ffff);
		send_command(CMD_INSERT, -32768, 32'sd7);
		send_command(CMD_INSERT, 32767, -32'sd1);
		send_command(CMD_INSERT, 1, 32'sd7);
		while (list_entries.size() < CAPACITY)
			send_command(CMD_ADD_BACK, $urandom_range(65535), $urandom);
		send_command(CMD_ADD_FRONT, 0, 32'sd1);
		send_command(CMD_ADD_BACK, 0, 32'sd1);
		send_command(CMD_INSERT, 3, 32'sd1);
		send_command(CMD_FIND, 0, list_entries[CAPACITY-1]);
		send_command(CMD_ERASE, -32768, 32'sd0);
		send_command(CMD_ERASE, 32767, 32'sd0);
		send_command(CMD_ERASE, CAPACITY, 32'sd0);
		send_command(CMD_CLEAR, 0, 32'sd0);
	endtask

	// Random commands, alternately biased towards growing and shrinking the
	// list, with a share of fully random noise.
	task automatic test_random_phase(input int idle_pct, input int count);
		int                 grow_w[8];
		int                 shrink_w[8];
		int                 roll;
		int                 acc;
		int                 n;
		logic [2:0]         cmd;
		int                 pos;
		logic signed [31:0] value;
		logic               grow;
		grow_w   = '{20, 20, 25, 7, 7, 8, 12, 1};
		shrink_w = '{8, 8, 8, 20, 20, 20, 15, 1};
		sender_idle_pct = idle_pct;
		grow = 1'b1;
		for (int i = 0; i < count; i++) begin
			if (i % SWING_ITEMS == SWING_ITEMS - 1) grow = !grow;
			n = list_entries.size();
			if ($urandom_range(99) < 10) begin
				cmd   = 3'($urandom_range(7));
				pos   = $urandom_range(65535);
				value = $urandom;
			end else begin
				roll = $urandom_range(99);
				acc  = 0;
				cmd  = CMD_FIND;
				for (int c = 0; c < 8; c++) begin
					acc += grow ? grow_w[c] : shrink_w[c];
					if (roll < acc) begin
						cmd = 3'(c);
						break;
					end
				end
				// Positions mostly near the valid range, sometimes anywhere.
				if ($urandom_range(99) < 80) pos = int'($urandom_range(n + 2)) - 1;
				else pos = $urandom_range(65535);
				// Small values give repeats for the first-match search.
				roll = $urandom_range(99);
				if (roll < 50) value = int'($urandom_range(7)) - 4;
				else if (roll < 60) value = 32'sh8000_0000;
				else if (roll < 70) value = 32'sh7fff_ffff;
				else value = $urandom;
				if (cmd == CMD_FIND && n > 0 && $urandom_range(99) < 60)
					value = list_entries[$urandom_range(n - 1)];
			end
			send_command(cmd, pos, value);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_list();
		test_fill_and_overflow();
		test_random_phase(25, PHASE_ITEMS);
		test_random_phase(79, PHASE_ITEMS);
		test_random_phase(0, PHASE_ITEMS);

		@(negedge clk);
		start <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d commands and checked %0d results", n_sent, n_checked);
		$display("Full list %0d times, ignored %0d times, find hits %0d",
			n_full, n_ignored, n_found);
		if (n_errors == 0 && pending_rsp.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
